// File: hdl/target_from_difficulty_divider_core_assert.svh
`ifndef TARGET_FROM_DIFFICULTY_DIVIDER_CORE_ASSERT_SVH
`define TARGET_FROM_DIFFICULTY_DIVIDER_CORE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define TFDD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("tfdd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TFDD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tfdd assertion failed");

`endif

// File: hdl/tfdd_pkg.sv
`default_nettype none
package tfdd_pkg;

  localparam int LIMB_BITS  = 64;
  localparam int STEP_W     = $clog2(LIMB_BITS);
  localparam int LIMB_IDX_W = 3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } tfdd_state_e;

  typedef struct packed {
    logic clear;  // zero the carried remainder at the start of a division
    logic step;   // one quotient bit
  } tfdd_ctl_t;

endpackage
`default_nettype wire

// File: hdl/target_from_difficulty_divider_core.sv
// Target from difficulty: divides the all-ones value of NUM_LIMBS*64 bits by
// a 64-bit difficulty (zero is taken as one) and returns the quotient as
// NUM_LIMBS words of 64 bits, most significant first.
// Input channel: in_valid_i / in_stall_o with difficulty_i. A word is taken
// when valid is high and stall is low; stall stays high while a division runs.
// Output channel: out_valid_o / out_stall_i with limb_index_o, quotient_limb_o
// and last_o; last_o marks the least significant word.
// Each word is built by repeated passes through the shared 64-bit
// subtract-and-compare of the bit-serial divider, then a hand-off state.
// A new difficulty is taken as soon as the last word enters the output
// register, even while that word still waits.
// If the receiver stalls, the finished word is held in the divider and the
// sequencer waits until the output register frees.
// Reset clears the sequencer and drops out_valid_o.
`default_nettype none
module target_from_difficulty_divider_core
  import tfdd_pkg::*;
#(
  parameter int NUM_LIMBS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [63:0]           difficulty_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [LIMB_IDX_W-1:0]      limb_index_o,
  output logic [LIMB_BITS-1:0]       quotient_limb_o,
  output logic                       last_o
);

  localparam int LimbCntW = (NUM_LIMBS > 1) ? $clog2(NUM_LIMBS) : 1;

  tfdd_state_e state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [LimbCntW-1:0] limb_q, limb_d;
  logic [LIMB_BITS-1:0] divisor_q;
  tfdd_ctl_t ctl;
  logic accept, out_free, out_load, step_end, limb_end;
  logic [LIMB_BITS-1:0] quotient;
  logic [LimbCntW+LIMB_IDX_W-1:0] limb_ext;

  logic                  out_valid_q, out_valid_d;
  logic [LIMB_IDX_W-1:0] out_idx_q;
  logic [LIMB_BITS-1:0]  out_quot_q;
  logic                  out_last_q;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign step_end = step_q == STEP_W'(LIMB_BITS - 1);
  assign limb_end = limb_q == LimbCntW'(NUM_LIMBS - 1);
  assign limb_ext = {{LIMB_IDX_W{1'b0}}, limb_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DIV;
      S_DIV:  if (step_end) state_d = S_EMIT;
      S_EMIT: if (out_free) state_d = limb_end ? S_IDLE : S_DIV;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    ctl        = '0;
    out_load   = 1'b0;
    step_d     = step_q;
    limb_d     = limb_q;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        ctl.clear  = in_valid_i;
        step_d     = '0;
        limb_d     = '0;
      end
      S_DIV: begin
        ctl.step = 1'b1;
        step_d   = step_q + 1'b1;
      end
      S_EMIT: begin
        out_load = out_free;
        if (out_free) limb_d = limb_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      limb_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      limb_q      <= limb_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      divisor_q <= (difficulty_i == '0) ? LIMB_BITS'(1) : difficulty_i;
    end
    if (out_load) begin
      out_idx_q  <= limb_ext[LIMB_IDX_W-1:0];
      out_quot_q <= quotient;
      out_last_q <= limb_end;
    end
  end

  tfdd_bitdiv u_bitdiv (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .divisor_i  (divisor_q),
    .quotient_o (quotient)
  );

  assign out_valid_o     = out_valid_q;
  assign limb_index_o    = out_idx_q;
  assign quotient_limb_o = out_quot_q;
  assign last_o          = out_last_q;

endmodule
`default_nettype wire

// File: hdl/tfdd_bitdiv.sv
`default_nettype none
// Bit-serial restoring divider. The dividend limb is all ones, so a one is
// shifted in on every step; the remainder carries over from limb to limb.
module tfdd_bitdiv
  import tfdd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire tfdd_ctl_t            ctl_i,
  input  wire logic [LIMB_BITS-1:0] divisor_i,
  output logic      [LIMB_BITS-1:0] quotient_o
);

  logic [LIMB_BITS-1:0] part_q, part_d;
  logic [LIMB_BITS-1:0] quot_q, quot_d;
  logic [LIMB_BITS:0]   shifted;
  logic [LIMB_BITS:0]   diff;
  logic                 ge;

  always_comb begin
    shifted = {part_q, 1'b1};
    diff    = shifted - {1'b0, divisor_i};
    ge      = ~diff[LIMB_BITS];
    part_d  = part_q;
    quot_d  = quot_q;
    if (ctl_i.clear) begin
      part_d = '0;
      quot_d = '0;
    end else if (ctl_i.step) begin
      part_d = ge ? diff[LIMB_BITS-1:0] : shifted[LIMB_BITS-1:0];
      quot_d = {quot_q[LIMB_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    quot_q <= quot_d;
  end

  assign quotient_o = quot_q;

endmodule
`default_nettype wire

// File: hdl/tfdd_checker.sv
`default_nettype none
`include "target_from_difficulty_divider_core_assert.svh"
module tfdd_checker #(
  parameter int NUM_LIMBS = 8
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  limb_index_o,
  input wire logic [63:0] quotient_limb_o,
  input wire logic        last_o
);

  localparam logic [2:0] LastIdx = 3'((NUM_LIMBS - 1) % 8);

  // a held word keeps its payload
  `TFDD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(quotient_limb_o) && $stable(limb_index_o) && $stable(last_o))

  // once a difficulty is taken the block is busy
  `TFDD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // the flagged word sits at the least significant position
  `TFDD_ASSERT(a_last_index, clk_i, rst_ni, !(out_valid_o && last_o) || limb_index_o == LastIdx)

endmodule

bind target_from_difficulty_divider_core tfdd_checker #(.NUM_LIMBS(NUM_LIMBS)) u_tfdd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .limb_index_o    (limb_index_o),
  .quotient_limb_o (quotient_limb_o),
  .last_o          (last_o)
);
`default_nettype wire

// File: verif/target_from_difficulty_divider_core_test.sv
`default_nettype none
module target_from_difficulty_divider_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tfdd_pkg::*;

  localparam int NUM_LIMBS   = 8;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE      = 600;  // a touch over one whole division

  typedef struct packed {
    logic [LIMB_IDX_W-1:0] index;
    logic [LIMB_BITS-1:0]  value;
    logic                  last;
  } target_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [63:0]           difficulty_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [LIMB_IDX_W-1:0] limb_index_o;
  logic [LIMB_BITS-1:0]  quotient_limb_o;
  logic                  last_o;

  logic [63:0]  pending_difficulties[$];
  target_word_t target_words[$];
  int           sender_idle_pct = 0;
  int           stall_pct = 0;
  int           failures = 0;
  int           hold_left = 0;
  logic         hold_req = 1'b0;
  logic         hold_taken = 1'b0;

  target_from_difficulty_divider_core #(.NUM_LIMBS(NUM_LIMBS)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .difficulty_i    (difficulty_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .limb_index_o    (limb_index_o),
    .quotient_limb_o (quotient_limb_o),
    .last_o          (last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // (2^512-1) / difficulty, long division limb by limb, remainder carried on.
  function automatic void predict_target(input logic [63:0] difficulty);
    logic [63:0]  divisor;
    logic [63:0]  carry;
    logic [127:0] dividend;
    target_word_t w;
    divisor = (difficulty == 64'd0) ? 64'd1 : difficulty;
    carry = '0;
    for (int i = 0; i < NUM_LIMBS; i++) begin
      dividend = {carry, {64{1'b1}}};
      w.index = LIMB_IDX_W'(i);
      w.value = 64'(dividend / {64'd0, divisor});
      w.last = (i == NUM_LIMBS - 1);
      carry = 64'(dividend % {64'd0, divisor});
      target_words.push_back(w);
    end
  endfunction

  function automatic logic [63:0] random_difficulty();
    logic [63:0] d;
    case ($urandom_range(4))
      0: d = {$urandom, $urandom};
      1: d = 64'($urandom_range(300));
      2: d = (64'd1 << $urandom_range(63)) + 64'($urandom_range(2)) - 64'd1;
      3: d = {$urandom, $urandom} >> $urandom_range(63);
      default: d = ~64'($urandom_range(255));
    endcase
    return d;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // Sender: one word per pending difficulty, held steady while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      difficulty_i <= '0;
    end else begin
      logic taken;
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        predict_target(difficulty_i);
        void'(pending_difficulties.pop_front());
      end
      if (!in_valid_i || taken) begin
        if (pending_difficulties.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid_i <= 1'b1;
          difficulty_i <= pending_difficulties[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      target_word_t want;
      if (target_words.size() == 0) begin
        note_failure($sformatf("unexpected word: index %0d limb %h last %b",
                               limb_index_o, quotient_limb_o, last_o));
      end else begin
        want = target_words.pop_front();
        if (limb_index_o !== want.index || quotient_limb_o !== want.value ||
            last_o !== want.last)
          note_failure($sformatf(
            "word mismatch: expected index %0d limb %h last %b, got index %0d limb %h last %b",
            want.index, want.value, want.last, limb_index_o, quotient_limb_o, last_o));
      end
    end
  end

  task automatic drain();
    while (pending_difficulties.size() != 0 || target_words.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic run_phase(input int idle_pct, input int stall, input int count);
    sender_idle_pct = idle_pct;
    stall_pct = stall;
    repeat (count) pending_difficulties.push_back(random_difficulty());
    drain();
  endtask

  initial begin
    logic [63:0] directed[$];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero and one both give all-ones limbs; the rest probe the divisor range
    directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd7, 64'd10, 64'hff,
                 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_fffe,
                 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
                 64'h8000_0000_0000_0001, 64'h0000_0001_0000_0000,
                 64'h0000_0000_ffff_ffff, 64'h5555_5555_5555_5555,
                 64'haaaa_aaaa_aaaa_aaaa, 64'h0123_4567_89ab_cdef,
                 64'hfedc_ba98_7654_3210, 64'd65537, 64'd1000003};
    foreach (directed[i]) pending_difficulties.push_back(directed[i]);
    drain();

    // long hold-off on the output while items keep coming
    sender_idle_pct = 0;
    stall_pct = 0;
    repeat (4) pending_difficulties.push_back(random_difficulty());
    hold_req <= 1'b1;
    drain();

    run_phase(0, 0, 50);
    run_phase(72, 0, 50);
    run_phase(0, 72, 50);
    run_phase(20, 20, 50);

    repeat (SETTLE) @(posedge clk_i);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(64'd8_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
